### sv/hcb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the Huffman code builder.
// Used by hcb_ctrl, hcb_datapath and huffman_code_builder; depends on nothing.
package hcb_pkg;

	localparam int MAX_SYMBOLS = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int NODE_SLOTS  = 2 * MAX_SYMBOLS;
	localparam int NODE_W      = $clog2(NODE_SLOTS);
	localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
	localparam int WSUM_W      = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
	localparam int SYMBOL_W    = 4;
	localparam int CODE_W      = 15;
	localparam int CODE_IDX_W  = $clog2(CODE_W);
	localparam int LEN_W       = 4;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight;
		logic                   last;
	} hcb_item_t;

	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic [CODE_W-1:0]   code_bits;
		logic [LEN_W-1:0]    code_length;
		logic                final_res;
		logic                overflow;
	} hcb_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_MERGE,
		ST_TRACE_INIT,
		ST_TRACE_STEP
	} hcb_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic clear;
		logic scan;
		logic merge;
		logic trace_init;
		logic trace_step;
		logic emit;
		logic next_sym;
		logic restart;
	} hcb_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic single;
		logic scan_last;
		logic merge_last;
		logic trace_end;
		logic sym_last;
	} hcb_status_t;

endpackage

### sv/huffman_code_builder.sv
`timescale 1ns / 1ps
// Huffman code builder top level. Weight items are taken back to back while idle; the item
// marked last starts a clear step and a tree build of n-1 merges, each a scan of the free
// nodes followed by a merge step, all through a single node-table read port. Codes are then
// traced one symbol at a time, one result strobe per symbol; the receiver cannot stall.
// busy is high from the last item until the final result.
// arst_n clears count, flags, FSM. Depends on hcb_pkg, hcb_ctrl and hcb_datapath.
module huffman_code_builder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  hcb_pkg::hcb_item_t   item,
	output logic                 busy,
	output logic                 result_strobe,
	output hcb_pkg::hcb_result_t result
);
	import hcb_pkg::*;

	hcb_cmd_t    cmd;
	hcb_status_t status;

	hcb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (item.last),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	hcb_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.cmd           (cmd),
		.status        (status),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule

### sv/hcb_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the Huffman code builder: collect, tree build, code trace.
// Depends on hcb_pkg.
module hcb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               last,
	input  hcb_pkg::hcb_status_t status,
	output hcb_pkg::hcb_cmd_t    cmd,
	output logic               busy
);
	import hcb_pkg::*;

	hcb_state_t state_q;
	hcb_state_t state_nxt;
	logic       accept;

	assign accept = start && (state_q == ST_IDLE);

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && last) begin
					state_nxt = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				state_nxt = status.single ? ST_TRACE_INIT : ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_last) begin
					state_nxt = ST_MERGE;
				end
			end
			ST_MERGE: begin
				state_nxt = status.merge_last ? ST_TRACE_INIT : ST_SCAN;
			end
			ST_TRACE_INIT: begin
				state_nxt = ST_TRACE_STEP;
			end
			ST_TRACE_STEP: begin
				if (status.trace_end) begin
					state_nxt = status.sym_last ? ST_IDLE : ST_TRACE_INIT;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Commands for the datapath
	always_comb begin
		cmd            = '0;
		cmd.load       = accept;
		cmd.clear      = (state_q == ST_CLEAR);
		cmd.scan       = (state_q == ST_SCAN);
		cmd.merge      = (state_q == ST_MERGE);
		cmd.trace_init = (state_q == ST_TRACE_INIT);
		cmd.trace_step = (state_q == ST_TRACE_STEP) && !status.trace_end;
		cmd.emit       = (state_q == ST_TRACE_STEP) && status.trace_end;
		cmd.next_sym   = cmd.emit && !status.sym_last;
		cmd.restart    = cmd.emit && status.sym_last;
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### sv/hcb_datapath.sv
`timescale 1ns / 1ps
// Node table, two-minimum scan, merge and parent-walk code tracer.
// Depends on hcb_pkg; driven by hcb_ctrl commands.
module hcb_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hcb_pkg::hcb_item_t   item,
	input  hcb_pkg::hcb_cmd_t    cmd,
	output hcb_pkg::hcb_status_t status,
	output logic                 result_strobe,
	output hcb_pkg::hcb_result_t result
);
	import hcb_pkg::*;

	// Node table; index 0 is unused, leaves are 1..n
	logic [WSUM_W-1:0]     weight_q [NODE_SLOTS];
	logic [NODE_W-1:0]     parent_q [NODE_SLOTS];
	logic [NODE_W-1:0]     left_q   [NODE_SLOTS];
	logic [NODE_SLOTS-1:0] parent_vld_q;

	logic [CNT_W-1:0]  count_q;
	logic              dropped_q;
	logic [NODE_W-1:0] node_q;
	logic [NODE_W-1:0] scan_q;
	logic [NODE_W-1:0] sym_q;
	logic              found1_q;
	logic              found2_q;
	logic [NODE_W-1:0] best1_q;
	logic [NODE_W-1:0] best2_q;
	logic [WSUM_W-1:0] wmin1_q;
	logic [WSUM_W-1:0] wmin2_q;
	logic [NODE_W-1:0] child_q;
	logic [NODE_W-1:0] up_q;
	logic [CODE_W-1:0] code_q;
	logic [NODE_W-1:0] len_q;
	logic              strobe_q;
	hcb_result_t       result_q;

	logic [NODE_W-1:0] n_node;
	logic [CNT_W:0]    two_n;
	logic [NODE_W-1:0] top_node;
	logic              has_room;
	logic [WSUM_W-1:0] rd_weight;
	logic              rd_free;
	logic [NODE_W-1:0] tr_addr;
	logic [NODE_W-1:0] par_rd;
	logic [NODE_W-1:0] left_rd;
	logic              take1;
	logic              take2;
	logic [NODE_W-1:0] lo_idx;
	logic [NODE_W-1:0] hi_idx;
	logic [WSUM_W-1:0] merge_sum;

	// Set size and last node of the tree
	assign n_node   = NODE_W'(count_q);
	assign two_n    = {count_q, 1'b0};
	assign top_node = NODE_W'(two_n - (CNT_W + 1)'(1));
	assign has_room = (count_q < CNT_W'(MAX_SYMBOLS));

	// Scan read port and running two-minimum update
	assign rd_weight = weight_q[scan_q];
	assign rd_free   = !parent_vld_q[scan_q];
	assign take1     = rd_free && (!found1_q || (rd_weight < wmin1_q));
	assign take2     = rd_free && !take1 && (!found2_q || (rd_weight < wmin2_q));

	// Merge pair, lower index goes left
	assign lo_idx    = (best1_q < best2_q) ? best1_q : best2_q;
	assign hi_idx    = (best1_q < best2_q) ? best2_q : best1_q;
	assign merge_sum = wmin1_q + wmin2_q;

	// Trace read port; an entry without a valid parent reads as no parent
	assign tr_addr = cmd.trace_init ? sym_q : up_q;
	assign par_rd  = parent_vld_q[tr_addr] ? parent_q[tr_addr] : '0;
	assign left_rd = left_q[up_q];

	// Status for the controller
	assign status.single     = (count_q == CNT_W'(1));
	assign status.scan_last  = (scan_q == node_q - NODE_W'(1));
	assign status.merge_last = (node_q == top_node);
	assign status.trace_end  = (up_q == '0);
	assign status.sym_last   = (sym_q == n_node);

	// Control state: fill count, drop flag, valid bits, counters, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			dropped_q    <= 1'b0;
			parent_vld_q <= '0;
			node_q       <= '0;
			scan_q       <= '0;
			sym_q        <= '0;
			found1_q     <= 1'b0;
			found2_q     <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.load) begin
				if (has_room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (cmd.restart) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end
			if (cmd.clear) begin
				parent_vld_q <= '0;
				node_q       <= n_node + NODE_W'(1);
				scan_q       <= NODE_W'(1);
				sym_q        <= NODE_W'(1);
				found1_q     <= 1'b0;
				found2_q     <= 1'b0;
			end
			if (cmd.scan) begin
				scan_q <= scan_q + NODE_W'(1);
				if (take1) begin
					found1_q <= 1'b1;
					found2_q <= found1_q;
				end else if (take2) begin
					found2_q <= 1'b1;
				end
			end
			if (cmd.merge) begin
				parent_vld_q[lo_idx] <= 1'b1;
				parent_vld_q[hi_idx] <= 1'b1;
				node_q               <= node_q + NODE_W'(1);
				scan_q               <= NODE_W'(1);
				found1_q             <= 1'b0;
				found2_q             <= 1'b0;
			end
			if (cmd.next_sym) begin
				sym_q <= sym_q + NODE_W'(1);
			end
		end
	end

	// Payload: node table, scan minima, trace registers, result
	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			weight_q[n_node + NODE_W'(1)] <= WSUM_W'(item.weight);
		end
		if (cmd.scan) begin
			if (take1) begin
				best1_q <= scan_q;
				wmin1_q <= rd_weight;
				best2_q <= best1_q;
				wmin2_q <= wmin1_q;
			end else if (take2) begin
				best2_q <= scan_q;
				wmin2_q <= rd_weight;
			end
		end
		if (cmd.merge) begin
			parent_q[lo_idx] <= node_q;
			parent_q[hi_idx] <= node_q;
			left_q[node_q]   <= lo_idx;
			weight_q[node_q] <= merge_sum;
		end
		if (cmd.trace_init) begin
			child_q <= sym_q;
			up_q    <= par_rd;
			code_q  <= '0;
			len_q   <= '0;
		end
		if (cmd.trace_step) begin
			if ((left_rd != child_q) && (len_q < NODE_W'(CODE_W))) begin
				code_q[len_q[CODE_IDX_W-1:0]] <= 1'b1;
			end
			len_q   <= len_q + NODE_W'(1);
			child_q <= up_q;
			up_q    <= par_rd;
		end
		if (cmd.emit) begin
			result_q.symbol      <= SYMBOL_W'(sym_q - NODE_W'(1));
			result_q.code_bits   <= code_q;
			result_q.code_length <= LEN_W'(len_q);
			result_q.final_res   <= status.sym_last;
			result_q.overflow    <= dropped_q;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

	// A merge always joins two distinct free nodes found by the scan
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge |-> (found1_q && found2_q && (best1_q != best2_q)))
		else $error("merge without two distinct minima");

	// The fill count never passes MAX_SYMBOLS, the symbol capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SYMBOLS))
		else $error("symbol count beyond table size");

	// Result strobes never come back to back; a trace start lies between them
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |=> !strobe_q)
		else $error("back-to-back result strobes");

	// A parent walk is shorter than MAX_SYMBOLS, the symbol capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.trace_step |-> (len_q < NODE_W'(MAX_SYMBOLS)))
		else $error("code longer than symbol count");

endmodule
